// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Expects signals clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/gha_pkg.sv -----
// Package for the generational handle allocator: port widths, opcodes,
// status codes and parameter defaults. No dependencies.
`default_nettype none

package gha_pkg;

    // Parameter defaults
    localparam int MAX_ENTITIES_DEF = 256;
    localparam int GEN_BITS_DEF     = 16;

    // Fixed port widths
    localparam int OPCODE_W = 2;
    localparam int HIDX_W   = 8;
    localparam int HGEN_W   = 16;
    localparam int STATUS_W = 2;
    localparam int ALIVE_W  = 9;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request opcodes
    localparam opcode_t OP_CREATE         = 2'd0;
    localparam opcode_t OP_DESTROY_HANDLE = 2'd1;
    localparam opcode_t OP_DESTROY_INDEX  = 2'd2;

    // Result status codes
    localparam status_t STATUS_DONE    = 2'd0;
    localparam status_t STATUS_IGNORED = 2'd1;
    localparam status_t STATUS_FULL    = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/gha_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. Defaults come from gha_pkg.
`default_nettype none

module gha_ram #(
    parameter int DEPTH = gha_pkg::MAX_ENTITIES_DEF,
    parameter int WIDTH = gha_pkg::HIDX_W
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/generational_handle_allocator_top.sv -----
// Generational handle allocator: one result word per request word.
// Accept loads the execute state, which then fills the result register and
// holds while a result waits. A new request is taken only in idle, after the
// read then write-back of the slot, position, dense and free-stack RAMs.
// Reset: counters and handshake state cleared; RAMs are not swept, slots at
// or above the used-slot count read as inactive and are created with generation zero.
`default_nettype none
`include "assert_macros.svh"

module generational_handle_allocator_top #(
    parameter int MAX_ENTITIES = gha_pkg::MAX_ENTITIES_DEF,
    parameter int GEN_BITS     = gha_pkg::GEN_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [gha_pkg::OPCODE_W-1:0] opcode,
    input  wire logic [gha_pkg::HIDX_W-1:0]   handle_index,
    input  wire logic [gha_pkg::HGEN_W-1:0]   handle_generation,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [gha_pkg::STATUS_W-1:0] status,
    output logic      [gha_pkg::HIDX_W-1:0]   entity_index,
    output logic      [gha_pkg::HGEN_W-1:0]   entity_generation,
    output logic      [gha_pkg::ALIVE_W-1:0]  alive_total
);

    localparam int IDX_W  = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
    localparam int SLOT_W = GEN_BITS + 1;
    localparam int FREE_W = IDX_W + GEN_BITS;

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    // Control and counters
    state_t                  state_reg, state_next;
    gha_pkg::opcode_t        op_reg, op_next;
    logic [IDX_W-1:0]        hidx_reg, hidx_next;
    logic                    idx_ok_reg, idx_ok_next;
    logic [gha_pkg::HGEN_W-1:0] hgen_reg, hgen_next;
    logic [CNT_W-1:0]        live_count_reg, live_count_next;
    logic [CNT_W-1:0]        free_depth_reg, free_depth_next;
    logic [CNT_W-1:0]        used_reg, used_next;

    // Result register
    logic                    out_valid_reg, out_valid_next;
    gha_pkg::status_t        status_reg, status_next;
    logic [gha_pkg::HIDX_W-1:0]  ent_idx_reg, ent_idx_next;
    logic [gha_pkg::HGEN_W-1:0]  ent_gen_reg, ent_gen_next;
    logic [gha_pkg::ALIVE_W-1:0] alive_reg, alive_next;

    // RAM ports
    logic                    acc;
    logic                    slot_we, pos_we, dense_we, free_we;
    logic [IDX_W-1:0]        slot_waddr, pos_waddr, dense_waddr, free_waddr;
    logic [SLOT_W-1:0]       slot_wdata, slot_rdata;
    logic [IDX_W-1:0]        pos_wdata, pos_rdata;
    logic [IDX_W-1:0]        dense_wdata, dense_rdata;
    logic [FREE_W-1:0]       free_wdata, free_rdata;
    logic [IDX_W-1:0]        hidx_in;
    logic [IDX_W-1:0]        dense_raddr, free_raddr;

    // Execute-cycle decode
    logic                    exec_fire;
    logic                    slot_active;
    logic [GEN_BITS-1:0]     slot_gen, gen_bumped;
    logic                    destroy_ok;
    logic                    from_free, fresh_room, create_ok;
    logic [IDX_W-1:0]        e_create;
    logic [GEN_BITS-1:0]     gen_create;
    logic                    free_room;

    // Assertion terms
    logic                    counts_ok;
    logic                    full_create;
    logic                    full_shown;
    logic                    destroy_fire;
    logic [CNT_W-1:0]        live_dec;

    assign in_ready  = (state_reg == S_IDLE);
    assign acc       = in_valid && in_ready;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // Read addresses issued at accept time
    assign hidx_in     = IDX_W'(handle_index);
    assign dense_raddr = IDX_W'(live_count_reg - 1'b1);
    assign free_raddr  = IDX_W'(free_depth_reg - 1'b1);

    // Slot word: {active, generation}; valid only below the used count
    assign slot_active = idx_ok_reg && slot_rdata[GEN_BITS];
    assign slot_gen    = slot_rdata[GEN_BITS-1:0];
    assign gen_bumped  = GEN_BITS'(slot_gen + 1'b1);

    assign destroy_ok = slot_active && (live_count_reg != '0) &&
                        ((op_reg == gha_pkg::OP_DESTROY_INDEX) ||
                         ((op_reg == gha_pkg::OP_DESTROY_HANDLE) &&
                          (gha_pkg::HGEN_W'(slot_gen) == hgen_reg)));

    // Create source: top of free stack, else next never-used slot
    assign from_free  = (free_depth_reg != '0);
    assign fresh_room = (32'(used_reg) < 32'(MAX_ENTITIES));
    assign create_ok  = (op_reg == gha_pkg::OP_CREATE) && (from_free || fresh_room);
    assign e_create   = from_free ? free_rdata[FREE_W-1:GEN_BITS] : IDX_W'(used_reg);
    assign gen_create = from_free ? free_rdata[GEN_BITS-1:0] : '0;
    assign free_room  = (32'(free_depth_reg) < 32'(MAX_ENTITIES));

    // Write-back to the RAMs in the execute cycle
    always_comb
    begin
        slot_we     = exec_fire && (create_ok || destroy_ok);
        pos_we      = slot_we;
        dense_we    = slot_we;
        free_we     = exec_fire && destroy_ok && free_room;
        slot_waddr  = create_ok ? e_create : hidx_reg;
        slot_wdata  = create_ok ? {1'b1, gen_create} : {1'b0, gen_bumped};
        // create records its dense position; destroy retargets the moved slot
        pos_waddr   = create_ok ? e_create : dense_rdata;
        pos_wdata   = create_ok ? IDX_W'(live_count_reg) : pos_rdata;
        // create appends; destroy swaps the last entry into the hole
        dense_waddr = create_ok ? IDX_W'(live_count_reg) : pos_rdata;
        dense_wdata = create_ok ? e_create : dense_rdata;
        free_waddr  = IDX_W'(free_depth_reg);
        free_wdata  = {hidx_reg, gen_bumped};
    end

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        hidx_next       = hidx_reg;
        idx_ok_next     = idx_ok_reg;
        hgen_next       = hgen_reg;
        live_count_next = live_count_reg;
        free_depth_next = free_depth_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        ent_idx_next    = ent_idx_reg;
        ent_gen_next    = ent_gen_reg;
        alive_next      = alive_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    op_next     = opcode;
                    hidx_next   = hidx_in;
                    idx_ok_next = (32'(handle_index) < 32'(used_reg));
                    hgen_next   = handle_generation;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = gha_pkg::STATUS_IGNORED;
                    ent_idx_next   = '0;
                    ent_gen_next   = '0;
                    unique case (op_reg)
                        gha_pkg::OP_CREATE:
                        begin
                            if (create_ok)
                            begin
                                status_next     = gha_pkg::STATUS_DONE;
                                ent_idx_next    = gha_pkg::HIDX_W'(e_create);
                                ent_gen_next    = gha_pkg::HGEN_W'(gen_create);
                                live_count_next = CNT_W'(live_count_reg + 1'b1);
                                if (from_free)
                                begin
                                    free_depth_next = CNT_W'(free_depth_reg - 1'b1);
                                end
                                else
                                begin
                                    used_next = CNT_W'(used_reg + 1'b1);
                                end
                            end
                            else
                            begin
                                status_next = gha_pkg::STATUS_FULL;
                            end
                        end
                        gha_pkg::OP_DESTROY_HANDLE, gha_pkg::OP_DESTROY_INDEX:
                        begin
                            if (destroy_ok)
                            begin
                                status_next     = gha_pkg::STATUS_DONE;
                                ent_idx_next    = gha_pkg::HIDX_W'(hidx_reg);
                                ent_gen_next    = gha_pkg::HGEN_W'(gen_bumped);
                                live_count_next = CNT_W'(live_count_reg - 1'b1);
                                if (free_room)
                                begin
                                    free_depth_next = CNT_W'(free_depth_reg + 1'b1);
                                end
                            end
                        end
                        default:
                        begin
                            status_next = gha_pkg::STATUS_IGNORED;
                        end
                    endcase
                    alive_next = gha_pkg::ALIVE_W'(live_count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= gha_pkg::OP_CREATE;
            hidx_reg       <= '0;
            idx_ok_reg     <= 1'b0;
            hgen_reg       <= '0;
            live_count_reg <= '0;
            free_depth_reg <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= gha_pkg::STATUS_DONE;
            ent_idx_reg    <= '0;
            ent_gen_reg    <= '0;
            alive_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            hidx_reg       <= hidx_next;
            idx_ok_reg     <= idx_ok_next;
            hgen_reg       <= hgen_next;
            live_count_reg <= live_count_next;
            free_depth_reg <= free_depth_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            ent_idx_reg    <= ent_idx_next;
            ent_gen_reg    <= ent_gen_next;
            alive_reg      <= alive_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign entity_index      = ent_idx_reg;
    assign entity_generation = ent_gen_reg;
    assign alive_total       = alive_reg;

    // Per-slot {active, generation}
    gha_ram #(.DEPTH(MAX_ENTITIES), .WIDTH(SLOT_W)) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_en   (acc),
        .rd_addr (hidx_in),
        .rd_data (slot_rdata)
    );

    // Per-slot position in the dense list
    gha_ram #(.DEPTH(MAX_ENTITIES), .WIDTH(IDX_W)) u_pos_ram (
        .clk     (clk),
        .wr_en   (pos_we),
        .wr_addr (pos_waddr),
        .wr_data (pos_wdata),
        .rd_en   (acc),
        .rd_addr (hidx_in),
        .rd_data (pos_rdata)
    );

    // Dense list of live slots
    gha_ram #(.DEPTH(MAX_ENTITIES), .WIDTH(IDX_W)) u_dense_ram (
        .clk     (clk),
        .wr_en   (dense_we),
        .wr_addr (dense_waddr),
        .wr_data (dense_wdata),
        .rd_en   (acc),
        .rd_addr (dense_raddr),
        .rd_data (dense_rdata)
    );

    // LIFO free stack: {slot, generation after destroy}
    gha_ram #(.DEPTH(MAX_ENTITIES), .WIDTH(FREE_W)) u_free_ram (
        .clk     (clk),
        .wr_en   (free_we),
        .wr_addr (free_waddr),
        .wr_data (free_wdata),
        .rd_en   (acc),
        .rd_addr (free_raddr),
        .rd_data (free_rdata)
    );

    // Terms checked below
    assign counts_ok    = (32'(free_depth_reg) + 32'(live_count_reg)) == 32'(used_reg);
    assign full_create  = exec_fire && (op_reg == gha_pkg::OP_CREATE) &&
                          !from_free && !fresh_room;
    assign full_shown   = out_valid_reg && (status_reg == gha_pkg::STATUS_FULL);
    assign destroy_fire = exec_fire && destroy_ok;
    assign live_dec     = CNT_W'(live_count_reg - 1'b1);

    // Every used slot is either live or on the free stack
    `ASSERT_ALWAYS(a_count_balance, counts_ok, "slot counters out of balance")
    // An accepted word always moves to the execute cycle
    `ASSERT_NEXT(a_accept_exec, acc, state_reg == S_EXEC, "accept did not enter execute")
    // Full is reported whenever a create finds no slot source left
    `ASSERT_NEXT(a_full_status, full_create, full_shown, "full create not reported")
    // A successful destroy drops the live count by one
    `ASSERT_NEXT(a_destroy_live, destroy_fire, live_count_reg == $past(live_dec), "live count off")

endmodule

`default_nettype wire
